>>> rtl/rcnh_pkg.sv
// Ray/circle nearest-hit package: widths, register indexes and payload types.
// Used by ray_circle_nearest_hit, rcnh_sqrt and rcnh_div; depends on nothing.
`default_nettype none

package rcnh_pkg;

   // Coordinate format: signed Q12.4
   localparam int COORD_BITS = 16;
   localparam int RADIUS_BITS = COORD_BITS - 1;

   // Datapath widths
   localparam int ROOT_BITS = 2 * COORD_BITS;       // integer square root result
   localparam int QUO_BITS = COORD_BITS + 4;        // offset quotient, bounds |W| + r
   localparam int DEND_BITS = 3 * COORD_BITS + 1;   // num * |d| + a/2
   localparam int DSOR_BITS = 2 * COORD_BITS;       // a = D.D
   localparam int LANES = 2;                        // x and y

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CIRCLE_RADIUS = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] dir_x;
      logic signed [COORD_BITS-1:0] dir_y;
      logic [RADIUS_BITS-1:0]       mover_radius;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] hit_x;
      logic signed [COORD_BITS-1:0] hit_y;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/rcnh_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband word alongside; no package dependency beyond defaults.
`default_nettype none

module rcnh_sqrt #(
   parameter int ROOT_BITS = rcnh_pkg::ROOT_BITS,
   parameter int SIDE_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [2*ROOT_BITS-1:0] in_radicand,
   input  logic [SIDE_BITS-1:0]   in_side,
   output logic                   out_valid,
   output logic [ROOT_BITS-1:0]   out_root,
   output logic [SIDE_BITS-1:0]   out_side
);

   localparam int RAD_W = 2 * ROOT_BITS;

   logic                 vld_ff  [ROOT_BITS];
   logic [RAD_W-1:0]     rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [SIDE_BITS-1:0] side_ff [ROOT_BITS];

   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
      localparam int BIT = ROOT_BITS - 1 - g;

      logic                 vld_prev;
      logic [RAD_W-1:0]     rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [SIDE_BITS-1:0] side_prev;
      logic [RAD_W-1:0]     trial;
      logic                 take;
      logic [RAD_W-1:0]     rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (g == 0) begin : g_head
         assign vld_prev  = in_valid;
         assign rem_prev  = in_radicand;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_body
         assign vld_prev  = vld_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
      assign trial   = ({{ROOT_BITS{1'b0}}, root_prev} << (BIT + 1))
                       | (RAD_W'(1) << (2 * BIT));
      assign take    = rem_prev >= trial;
      assign rem_in  = take ? rem_prev - trial : rem_prev;
      assign root_in = take ? root_prev | (ROOT_BITS'(1) << BIT) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (advance) begin
            vld_ff[g] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            side_ff[g] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

`default_nettype wire

>>> rtl/rcnh_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage.
// Depends on rcnh_pkg for the lane count and default widths.
`default_nettype none

module rcnh_div #(
   parameter int DEND_BITS = rcnh_pkg::DEND_BITS,
   parameter int DSOR_BITS = rcnh_pkg::DSOR_BITS,
   parameter int QUO_BITS  = rcnh_pkg::QUO_BITS,
   parameter int SIDE_BITS = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [DEND_BITS-1:0] in_dividend [rcnh_pkg::LANES],
   input  logic [DSOR_BITS-1:0] in_divisor,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [QUO_BITS-1:0]  out_quotient [rcnh_pkg::LANES],
   output logic [SIDE_BITS-1:0] out_side
);

   localparam int LANES = rcnh_pkg::LANES;

   logic                 vld_ff  [QUO_BITS];
   logic [DSOR_BITS-1:0] dsor_ff [QUO_BITS];
   logic [SIDE_BITS-1:0] side_ff [QUO_BITS];
   logic [DEND_BITS-1:0] dend_ff [QUO_BITS][LANES];
   logic [DSOR_BITS-1:0] rem_ff  [QUO_BITS][LANES];
   logic [QUO_BITS-1:0]  quo_ff  [QUO_BITS][LANES];

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
      localparam int BIT = QUO_BITS - 1 - g;

      logic                 vld_prev;
      logic [DSOR_BITS-1:0] dsor_prev;
      logic [SIDE_BITS-1:0] side_prev;

      if (g == 0) begin : g_head
         assign vld_prev  = in_valid;
         assign dsor_prev = in_divisor;
         assign side_prev = in_side;
      end else begin : g_body
         assign vld_prev  = vld_ff[g-1];
         assign dsor_prev = dsor_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (advance) begin
            vld_ff[g] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dsor_ff[g] <= dsor_prev;
            side_ff[g] <= side_prev;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DEND_BITS-1:0] dend_prev;
         logic [DSOR_BITS-1:0] rem_prev;
         logic [QUO_BITS-1:0]  quo_prev;
         logic [DSOR_BITS:0]   rem_shift;
         logic                 take;
         logic [DSOR_BITS-1:0] rem_in;
         logic [QUO_BITS-1:0]  quo_in;

         if (g == 0) begin : g_head
            // quotient fits QUO_BITS, so the upper dividend part is below the divisor
            assign dend_prev = in_dividend[l];
            assign rem_prev  = DSOR_BITS'(in_dividend[l] >> QUO_BITS);
            assign quo_prev  = '0;
         end else begin : g_body
            assign dend_prev = dend_ff[g-1][l];
            assign rem_prev  = rem_ff[g-1][l];
            assign quo_prev  = quo_ff[g-1][l];
         end

         assign rem_shift = {rem_prev, dend_prev[BIT]};
         assign take      = rem_shift >= {1'b0, dsor_prev};
         assign rem_in    = take ? DSOR_BITS'(rem_shift - {1'b0, dsor_prev})
                                 : DSOR_BITS'(rem_shift);
         assign quo_in    = take ? quo_prev | (QUO_BITS'(1) << BIT) : quo_prev;

         always_ff @(posedge clock) begin
            if (advance) begin
               dend_ff[g][l] <= dend_prev;
               rem_ff[g][l]  <= rem_in;
               quo_ff[g][l]  <= quo_in;
            end
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quotient[l] = quo_ff[QUO_BITS-1][l];
   end
   assign out_valid = vld_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];

endmodule

`default_nettype wire

>>> rtl/ray_circle_nearest_hit.sv
// Nearest forward intersection of a ray's line with a configured, grown circle.
// Depends on rcnh_pkg, rcnh_sqrt and rcnh_div.
//
// Usage:
//   Configuration: write center_x, center_y and circle_radius through csr_we,
//   csr_index and csr_wdata while no transaction is in flight. Reset sets all
//   three to zero. Writes to unused indexes are dropped.
//   Request channel: req_valid/req_stall/req_data carries one ray per transaction
//   (origin and direction signed Q12.4, mover radius unsigned Q11.4).
//   Response channel: rsp_valid/rsp_stall/rsp_data returns exactly one result
//   per ray, in order: hit flag and the saturated hit point, zero on a miss.
// Timing:
//   One ray enters per cycle while req_stall is low. The pipeline has
//   5 + 2*COORD_BITS + 2 + (COORD_BITS+4) + 1 = 60 register stages at 16-bit
//   coordinates, set by the one-bit-per-stage square root and the two-lane divider.
//   The whole pipeline moves as one: when the output register holds a result
//   and rsp_stall is high, every stage holds and req_stall rises in the same
//   cycle; nothing is dropped or repeated. Otherwise a new ray is taken even
//   while earlier rays are still in flight.
//   Reset clears all valid bits and the configuration; payload registers keep
//   whatever they held.
`default_nettype none

module ray_circle_nearest_hit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rcnh_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rcnh_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [rcnh_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rcnh_pkg::COORD_BITS-1:0]       csr_wdata
);

   localparam int CB    = rcnh_pkg::COORD_BITS;
   localparam int RB    = rcnh_pkg::RADIUS_BITS;
   localparam int SHW   = $clog2(CB);
   localparam int P1    = 2 * CB + 1;   // w*d products
   localparam int P2    = 2 * CB + 2;   // b, cross, |W|^2
   localparam int ROOT  = rcnh_pkg::ROOT_BITS;
   localparam int QB    = rcnh_pkg::QUO_BITS;
   localparam int DEND  = rcnh_pkg::DEND_BITS;
   localparam int DSOR  = rcnh_pkg::DSOR_BITS;
   localparam int LANES = rcnh_pkg::LANES;
   localparam int SUMW  = CB + 6;

   typedef struct packed {
      logic                  nohit;
      logic signed [P2-1:0]  b;
      logic [DSOR-1:0]       a;
      logic signed [CB-1:0]  ox;
      logic signed [CB-1:0]  oy;
      logic signed [CB-1:0]  dx;
      logic signed [CB-1:0]  dy;
   } sq_side_type;

   typedef struct packed {
      logic                  nohit;
      logic signed [CB-1:0]  ox;
      logic signed [CB-1:0]  oy;
      logic                  dx_neg;
      logic                  dy_neg;
   } dv_side_type;

   // Global stage enable: hold everything while a finished result waits
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   //---------------------------------------------------------------- config
   logic signed [CB-1:0] center_x_ff, center_y_ff;
   logic [RB-1:0]        circle_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         circle_radius_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rcnh_pkg::CSR_CENTER_X:      center_x_ff      <= csr_wdata;
            rcnh_pkg::CSR_CENTER_Y:      center_y_ff      <= csr_wdata;
            rcnh_pkg::CSR_CIRCLE_RADIUS: circle_radius_ff <= csr_wdata[RB-1:0];
            default: ;
         endcase
      end
   end

   //---------------------------------------------------------------- stage 1
   // Offset from center, grown radius, and direction scaled up so that its
   // larger component reaches 2^(CB-2); the line stays the same.
   logic [CB-1:0]         mag_dx, mag_dy, mag_max;
   logic [SHW-1:0]        lead, shift;
   logic                  v1_ff, dz1_ff;
   logic signed [CB-1:0]  ox1_ff, oy1_ff, dx1_ff, dy1_ff;
   logic signed [CB:0]    wx1_ff, wy1_ff;
   logic [CB-1:0]         r1_ff;

   assign mag_dx  = req_data.dir_x[CB-1] ? CB'(~req_data.dir_x + 1'b1) : CB'(req_data.dir_x);
   assign mag_dy  = req_data.dir_y[CB-1] ? CB'(~req_data.dir_y + 1'b1) : CB'(req_data.dir_y);
   assign mag_max = (mag_dx > mag_dy) ? mag_dx : mag_dy;

   always_comb begin
      lead = '0;
      for (int i = 0; i < CB; i++) begin
         if (mag_max[i]) begin
            lead = SHW'(i);
         end
      end
   end

   assign shift = (lead < SHW'(CB - 2)) ? SHW'(CB - 2) - lead : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ox1_ff <= req_data.origin_x;
         oy1_ff <= req_data.origin_y;
         dx1_ff <= req_data.dir_x <<< shift;
         dy1_ff <= req_data.dir_y <<< shift;
         wx1_ff <= (CB+1)'(req_data.origin_x) - (CB+1)'(center_x_ff);
         wy1_ff <= (CB+1)'(req_data.origin_y) - (CB+1)'(center_y_ff);
         r1_ff  <= CB'(circle_radius_ff) + CB'(req_data.mover_radius);
         dz1_ff <= (mag_max == '0);
      end
   end

   //---------------------------------------------------------------- stage 2
   // All products of the components
   logic                  v2_ff, dz2_ff;
   logic signed [CB-1:0]  ox2_ff, oy2_ff, dx2_ff, dy2_ff;
   logic signed [P1-1:0]  wxdx2_ff, wydy2_ff, wxdy2_ff, wydx2_ff;
   logic signed [2*CB-1:0] dxx_in, dyy_in;
   logic signed [P2-1:0]  wxx_in, wyy_in;
   logic [2*CB-2:0]       dxx2_ff, dyy2_ff;
   logic [P1-1:0]         wxx2_ff, wyy2_ff;
   logic [2*CB-1:0]       rr2_ff;

   assign dxx_in = (2*CB)'(dx1_ff) * (2*CB)'(dx1_ff);
   assign dyy_in = (2*CB)'(dy1_ff) * (2*CB)'(dy1_ff);
   assign wxx_in = P2'(wx1_ff) * P2'(wx1_ff);
   assign wyy_in = P2'(wy1_ff) * P2'(wy1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ox2_ff   <= ox1_ff;
         oy2_ff   <= oy1_ff;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         dz2_ff   <= dz1_ff;
         wxdx2_ff <= P1'(wx1_ff) * P1'(dx1_ff);
         wydy2_ff <= P1'(wy1_ff) * P1'(dy1_ff);
         wxdy2_ff <= P1'(wx1_ff) * P1'(dy1_ff);
         wydx2_ff <= P1'(wy1_ff) * P1'(dx1_ff);
         dxx2_ff  <= dxx_in[2*CB-2:0];
         dyy2_ff  <= dyy_in[2*CB-2:0];
         wxx2_ff  <= wxx_in[P1-1:0];
         wyy2_ff  <= wyy_in[P1-1:0];
         rr2_ff   <= (2*CB)'(r1_ff) * (2*CB)'(r1_ff);
      end
   end

   //---------------------------------------------------------------- stage 3
   // a = D.D, b = W.D, |W x D|, and W.W against r^2
   logic                  v3_ff, dz3_ff, gt3_ff, lt3_ff;
   logic signed [CB-1:0]  ox3_ff, oy3_ff, dx3_ff, dy3_ff;
   logic [DSOR-1:0]       a3_ff;
   logic signed [P2-1:0]  b3_ff;
   logic signed [P2-1:0]  cross_in;
   logic [P1-1:0]         crm3_ff;
   logic [P2-1:0]         w2_in;
   logic [2*CB-1:0]       rr3_ff;

   assign cross_in = P2'(wxdy2_ff) - P2'(wydx2_ff);
   assign w2_in    = P2'(wxx2_ff) + P2'(wyy2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ox3_ff  <= ox2_ff;
         oy3_ff  <= oy2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         dz3_ff  <= dz2_ff;
         a3_ff   <= DSOR'(dxx2_ff) + DSOR'(dyy2_ff);
         b3_ff   <= P2'(wxdx2_ff) + P2'(wydy2_ff);
         crm3_ff <= cross_in[P2-1] ? P1'(-cross_in) : P1'(cross_in);
         gt3_ff  <= w2_in > P2'(rr2_ff);
         lt3_ff  <= w2_in < P2'(rr2_ff);
         rr3_ff  <= rr2_ff;
      end
   end

   //---------------------------------------------------------------- stage 4
   // a*r^2 and cross^2
   logic                  v4_ff, dz4_ff, gt4_ff, lt4_ff;
   logic signed [CB-1:0]  ox4_ff, oy4_ff, dx4_ff, dy4_ff;
   logic [DSOR-1:0]       a4_ff;
   logic signed [P2-1:0]  b4_ff;
   logic [4*CB-1:0]       ar2_4_ff;
   logic [4*CB+1:0]       cr2_4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ox4_ff   <= ox3_ff;
         oy4_ff   <= oy3_ff;
         dx4_ff   <= dx3_ff;
         dy4_ff   <= dy3_ff;
         dz4_ff   <= dz3_ff;
         gt4_ff   <= gt3_ff;
         lt4_ff   <= lt3_ff;
         a4_ff    <= a3_ff;
         b4_ff    <= b3_ff;
         ar2_4_ff <= (4*CB)'(a3_ff) * (4*CB)'(rr3_ff);
         cr2_4_ff <= (4*CB+2)'(crm3_ff) * (4*CB+2)'(crm3_ff);
      end
   end

   //---------------------------------------------------------------- stage 5
   // Discriminant and the miss decision; nearest root must lie forward
   logic                  v5_ff;
   logic [4*CB-1:0]       disc5_ff;
   sq_side_type           sq_side5_ff;
   logic                  miss_in;

   assign miss_in = cr2_4_ff > (4*CB+2)'(ar2_4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         disc5_ff          <= ar2_4_ff - (4*CB)'(cr2_4_ff);
         sq_side5_ff.nohit <= dz4_ff || miss_in || (b4_ff[P2-1] ? lt4_ff : gt4_ff);
         sq_side5_ff.b     <= b4_ff;
         sq_side5_ff.a     <= a4_ff;
         sq_side5_ff.ox    <= ox4_ff;
         sq_side5_ff.oy    <= oy4_ff;
         sq_side5_ff.dx    <= dx4_ff;
         sq_side5_ff.dy    <= dy4_ff;
      end
   end

   //---------------------------------------------------------------- square root
   logic                  sq_valid;
   logic [ROOT-1:0]       sq_root;
   logic [$bits(sq_side_type)-1:0] sq_side_bits;
   sq_side_type           sq_side;

   rcnh_sqrt #(
      .ROOT_BITS (ROOT),
      .SIDE_BITS ($bits(sq_side_type))
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (v5_ff),
      .in_radicand (disc5_ff),
      .in_side     (sq_side5_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side_bits)
   );

   assign sq_side = sq_side_bits;

   //---------------------------------------------------------------- stage 6
   // Numerator of the nearest root: s - b for b >= 0, -b - s otherwise
   logic                  v6_ff;
   logic signed [P2:0]    num_in;
   logic [P1-1:0]         num6_ff;
   logic [DSOR-1:0]       a6_ff;
   dv_side_type           dv_side6_ff;
   logic [CB-1:0]         mdx6_ff, mdy6_ff;

   assign num_in = sq_side.b[P2-1] ? (-(P2+1)'(sq_side.b) - $signed({3'b000, sq_root}))
                                   : ($signed({3'b000, sq_root}) - (P2+1)'(sq_side.b));

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num6_ff            <= num_in[P1-1:0];
         a6_ff              <= sq_side.a;
         mdx6_ff            <= sq_side.dx[CB-1] ? CB'(-sq_side.dx) : CB'(sq_side.dx);
         mdy6_ff            <= sq_side.dy[CB-1] ? CB'(-sq_side.dy) : CB'(sq_side.dy);
         dv_side6_ff.nohit  <= sq_side.nohit;
         dv_side6_ff.ox     <= sq_side.ox;
         dv_side6_ff.oy     <= sq_side.oy;
         dv_side6_ff.dx_neg <= sq_side.dx[CB-1];
         dv_side6_ff.dy_neg <= sq_side.dy[CB-1];
      end
   end

   //---------------------------------------------------------------- stage 7
   // Dividends num*|d| + a/2 for round-half-up of the offset
   logic                  v7_ff;
   logic [DEND-1:0]       dend7_ff [LANES];
   logic [DSOR-1:0]       a7_ff;
   dv_side_type           dv_side7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (advance) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dend7_ff[0] <= DEND'(num6_ff) * DEND'(mdx6_ff) + DEND'(a6_ff >> 1);
         dend7_ff[1] <= DEND'(num6_ff) * DEND'(mdy6_ff) + DEND'(a6_ff >> 1);
         a7_ff       <= a6_ff;
         dv_side7_ff <= dv_side6_ff;
      end
   end

   //---------------------------------------------------------------- divide
   logic                  dv_valid;
   logic [QB-1:0]         dv_quo [LANES];
   logic [$bits(dv_side_type)-1:0] dv_side_bits;
   dv_side_type           dv_side;

   rcnh_div #(
      .DEND_BITS (DEND),
      .DSOR_BITS (DSOR),
      .QUO_BITS  (QB),
      .SIDE_BITS ($bits(dv_side_type))
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (v7_ff),
      .in_dividend  (dend7_ff),
      .in_divisor   (a7_ff),
      .in_side      (dv_side7_ff),
      .out_valid    (dv_valid),
      .out_quotient (dv_quo),
      .out_side     (dv_side_bits)
   );

   assign dv_side = dv_side_bits;

   //---------------------------------------------------------------- output
   // Apply the offset along the direction sign, saturate, zero on a miss
   logic signed [SUMW-1:0] pos_in [LANES];
   logic signed [CB-1:0]   sat_in [LANES];
   logic                   rsp_valid_ff;
   rcnh_pkg::rsp_type      rsp_data_ff;

   localparam logic signed [SUMW-1:0] POS_MAX = SUMW'((64'sd1 <<< (CB - 1)) - 64'sd1);
   localparam logic signed [SUMW-1:0] POS_MIN = SUMW'(-(64'sd1 <<< (CB - 1)));

   always_comb begin
      pos_in[0] = dv_side.dx_neg ? SUMW'(dv_side.ox) - SUMW'(dv_quo[0])
                                 : SUMW'(dv_side.ox) + SUMW'(dv_quo[0]);
      pos_in[1] = dv_side.dy_neg ? SUMW'(dv_side.oy) - SUMW'(dv_quo[1])
                                 : SUMW'(dv_side.oy) + SUMW'(dv_quo[1]);
      for (int l = 0; l < LANES; l++) begin
         priority if (pos_in[l] > POS_MAX) begin
            sat_in[l] = POS_MAX[CB-1:0];
         end else if (pos_in[l] < POS_MIN) begin
            sat_in[l] = POS_MIN[CB-1:0];
         end else begin
            sat_in[l] = pos_in[l][CB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.hit   <= !dv_side.nohit;
         rsp_data_ff.hit_x <= dv_side.nohit ? '0 : sat_in[0];
         rsp_data_ff.hit_y <= dv_side.nohit ? '0 : sat_in[1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   //---------------------------------------------------------------- checks
   // Input side only stalls for a waiting, stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   // A miss always reports the origin-free zero point
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.hit_x == '0 && rsp_data.hit_y == '0))
      else $error("miss reported with nonzero coordinates");

   // Nothing comes out in the cycle after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A frozen pipeline keeps its stage contents
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(v1_ff) && $stable(v5_ff) && $stable(v7_ff)))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
